/* rtl/core/das_pkg.sv */
`timescale 1ns / 1ps
package das_pkg;
  localparam int TERM_BITS = 10;
  localparam int MAX_EDGES = 512;
  localparam int NODE_COUNT = 1 << TERM_BITS;
  localparam int EDGE_AW = $clog2(MAX_EDGES);
  localparam int CNT_W = EDGE_AW + 1;
  localparam int SP_W = TERM_BITS + 1;

  typedef logic [1:0] cmd_t;
  localparam cmd_t CMD_CLEAR = 2'd0;
  localparam cmd_t CMD_ADD   = 2'd1;
  localparam cmd_t CMD_QUERY = 2'd2;

  typedef logic [TERM_BITS-1:0] term_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the input item
    logic clr_count;
    logic add_edge;
    logic clr_vis;    // clear-pass step at vaddr_r
    logic scan_start; // begin scanning edges of cur node
    logic scan_step;  // one edge read / compare step
    logic pop;        // read top of stack
    logic take_pop;   // make popped value the current node
  } das_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic scan_done;
    logic stack_empty;
    logic hit;        // popped node equals target
    logic full;
  } das_sts_t;
endpackage

/* rtl/core/das_if.sv */
`timescale 1ns / 1ps
interface das_in_if;
  import das_pkg::*;
  logic valid;
  logic ready;
  cmd_t cmd;
  term_t term;
  term_t other_term;
  modport source (output valid, cmd, term, other_term, input ready);
  modport sink (input valid, cmd, term, other_term, output ready);
endinterface

interface das_out_if;
  logic valid;
  logic ready;
  logic is_ancestor;
  logic is_same;
  logic status;
  modport source (output valid, is_ancestor, is_same, status, input ready);
  modport sink (input valid, is_ancestor, is_same, status, output ready);
endinterface

/* rtl/core/das_ram.sv */
`timescale 1ns / 1ps
module das_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* rtl/core/das_datapath.sv */
`timescale 1ns / 1ps
module das_datapath (
  input  logic            clk,
  input  logic            rst_n,
  input  das_pkg::das_cmd_t cmd,
  input  das_pkg::term_t  in_term,
  input  das_pkg::term_t  in_other,
  output das_pkg::das_sts_t sts,
  output logic            same
);
  import das_pkg::*;

  term_t a_r, b_r, cur_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] idx_r;
  logic             rd_v_r;   // edge read data valid this cycle
  logic [SP_W-1:0]  sp_r;
  logic [TERM_BITS:0] vaddr_r; // clear sweep counter

  logic [2*TERM_BITS-1:0] e_rdata;
  logic [EDGE_AW-1:0]     e_raddr;
  logic [TERM_BITS-1:0]   s_rdata;
  logic [TERM_BITS-1:0]   v_raddr;
  logic                   v_rdata;
  term_t                  e_child, e_par;
  logic                   match, push;
  logic                   v_we;
  term_t                  v_waddr;
  logic                   v_wdata;

  // Edge reads are pipelined: address at idx, data in the next cycle.
  assign e_raddr = idx_r[EDGE_AW-1:0];
  assign e_child = e_rdata[2*TERM_BITS-1:TERM_BITS];
  assign e_par   = e_rdata[TERM_BITS-1:0];
  // Visited bit is read with the edge's parent: a second pipeline stage.
  logic  m_v_r;
  term_t m_par_r;
  assign v_raddr = e_par;
  assign match = rd_v_r && (e_child == cur_r);
  // A parent pushed last cycle must be seen as visited now.
  logic  lastpush_v_r;
  term_t lastpush_r;
  assign push = m_v_r && !v_rdata &&
                !(lastpush_v_r && lastpush_r == m_par_r);

  always_comb begin
    v_we = 1'b0;
    v_waddr = m_par_r;
    v_wdata = 1'b1;
    if (cmd.clr_vis) begin
      v_we = 1'b1;
      v_waddr = vaddr_r[TERM_BITS-1:0];
      v_wdata = 1'b0;
    end else if (push) begin
      v_we = 1'b1;
    end
  end

  // The edge is written in the cycle the item is taken, straight from the input.
  das_ram #(.WIDTH(2*TERM_BITS), .DEPTH(MAX_EDGES)) u_edges (
    .clk, .we(cmd.add_edge && !sts.full), .waddr(count_r[EDGE_AW-1:0]),
    .wdata({in_term, in_other}), .raddr(e_raddr), .rdata(e_rdata));

  logic [TERM_BITS-1:0] s_raddr;
  assign s_raddr = sp_r[TERM_BITS-1:0] - 1'b1;
  das_ram #(.WIDTH(TERM_BITS), .DEPTH(NODE_COUNT)) u_stack (
    .clk, .we(push), .waddr(sp_r[TERM_BITS-1:0]), .wdata(m_par_r),
    .raddr(s_raddr), .rdata(s_rdata));

  das_ram #(.WIDTH(1), .DEPTH(NODE_COUNT)) u_visited (
    .clk, .we(v_we), .waddr(v_waddr), .wdata(v_wdata),
    .raddr(v_raddr), .rdata(v_rdata));

  assign same = (a_r == b_r);
  assign sts.full = (count_r == CNT_W'(MAX_EDGES));
  assign sts.clr_done = vaddr_r[TERM_BITS];
  assign sts.stack_empty = (sp_r == '0);
  assign sts.hit = (s_rdata == b_r);
  assign sts.scan_done = (idx_r >= count_r) && !rd_v_r && !m_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      rd_v_r <= 1'b0;
      m_v_r <= 1'b0;
      lastpush_v_r <= 1'b0;
      sp_r <= '0;
      vaddr_r <= '0;
      idx_r <= '0;
    end else begin
      if (cmd.load) begin
        a_r <= in_term;
        b_r <= in_other;
        cur_r <= in_term;
        sp_r <= '0;
        vaddr_r <= '0;
      end
      if (cmd.clr_count) count_r <= '0;
      if (cmd.add_edge && !sts.full) count_r <= count_r + 1'b1;
      if (cmd.clr_vis) vaddr_r <= vaddr_r + 1'b1;
      if (cmd.take_pop) cur_r <= s_rdata;
      if (cmd.pop) sp_r <= sp_r - 1'b1;
      if (cmd.scan_start) idx_r <= '0;
      else if (cmd.scan_step && idx_r < count_r) idx_r <= idx_r + 1'b1;
      rd_v_r <= cmd.scan_step && !cmd.scan_start && idx_r < count_r;
      m_v_r <= match;
      m_par_r <= e_par;
      lastpush_v_r <= push;
      lastpush_r <= m_par_r;
      if (push) sp_r <= sp_r + 1'b1;
    end
  end
endmodule

/* rtl/core/das_ctrl.sv */
`timescale 1ns / 1ps
module das_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  das_pkg::cmd_t   in_cmd,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_anc,
  output logic            out_stat,
  output logic            res_same_en,
  output das_pkg::das_cmd_t cmd,
  input  das_pkg::das_sts_t sts
);
  import das_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CLR   = 7'b0000010,
    S_SCAN0 = 7'b0000100,
    S_SCAN  = 7'b0001000,
    S_POP   = 7'b0010000,
    S_CHK   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic anc_r, anc_nxt, stat_r, stat_nxt, qry_r, qry_nxt;

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_anc = anc_r;
  assign out_stat = stat_r;
  assign res_same_en = qry_r;

  always_comb begin
    state_nxt = state_r;
    anc_nxt = anc_r;
    stat_nxt = stat_r;
    qry_nxt = qry_r;
    cmd = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          anc_nxt = 1'b0;
          stat_nxt = 1'b0;
          qry_nxt = 1'b0;
          state_nxt = S_OUT;
          case (in_cmd)
            CMD_CLEAR: cmd.clr_count = 1'b1;
            CMD_ADD: begin
              stat_nxt = sts.full;
              cmd.add_edge = 1'b1;
            end
            CMD_QUERY: begin
              qry_nxt = 1'b1;
              state_nxt = S_CLR;
            end
            default: ;
          endcase
        end
      end
      S_CLR: begin
        if (sts.clr_done) state_nxt = S_SCAN0;
        else cmd.clr_vis = 1'b1;
      end
      S_SCAN0: begin
        cmd.scan_start = 1'b1;
        state_nxt = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) state_nxt = S_POP;
      end
      S_POP: begin
        if (sts.stack_empty) state_nxt = S_OUT;
        else begin
          cmd.pop = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (sts.hit) begin
          anc_nxt = 1'b1;
          state_nxt = S_OUT;
        end else begin
          cmd.take_pop = 1'b1;
          state_nxt = S_SCAN0;
        end
      end
      S_OUT: if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      anc_r <= 1'b0;
      stat_r <= 1'b0;
      qry_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      anc_r <= anc_nxt;
      stat_r <= stat_nxt;
      qry_r <= qry_nxt;
    end
  end
endmodule

/* rtl/core/dag_ancestor_search_top.sv */
`timescale 1ns / 1ps
// Channel | Role  | Payload
// in_     | sink  | cmd, term, other_term
// out_    | source| is_ancestor, is_same, status
// Clear and add go from idle straight to the result state. A query first
// sweeps the whole visited map, then for each node that it expands scans
// the edge table through the single read port of the edge memory. Reset
// is synchronous, active low, and empties the edge table. A stalled
// result holds the block busy.
module dag_ancestor_search_top (
  input logic clk,
  input logic rst_n,
  das_in_if.sink    in_ch,
  das_out_if.source out_ch
);
  import das_pkg::*;

  das_cmd_t cmd;
  das_sts_t sts;
  logic same, same_en;

  // The controller sequences the search; the datapath holds the memories.
  das_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_cmd(in_ch.cmd),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_anc(out_ch.is_ancestor), .out_stat(out_ch.status),
    .res_same_en(same_en), .cmd, .sts);

  das_datapath u_dp (
    .clk, .rst_n, .cmd, .in_term(in_ch.term), .in_other(in_ch.other_term),
    .sts, .same);

  // Equality is only reported for queries.
  assign out_ch.is_same = same_en & same;
endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
  import das_pkg::*;

  logic clk;
  logic rst_n;

  das_in_if  in_ch();
  das_out_if out_ch();

  dag_ancestor_search_top u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // One expected result of the block.
  typedef struct {
    logic is_ancestor;
    logic is_same;
    logic status;
  } verdict_t;

  // One row of the directed table. When has_exp is set, the expected result
  // is given in the row; otherwise the graph model computes it.
  typedef struct {
    cmd_t  cmd;
    term_t term;
    term_t other;
    bit    has_exp;
    logic  anc;
    logic  same;
    logic  full;
  } row_t;

  localparam cmd_t CMD_NONE = 2'd3;  // unused code, must be ignored

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // Graph model: a copy of the edge table and its fill count.
  term_t    edge_child [MAX_EDGES];
  term_t    edge_parent[MAX_EDGES];
  int       edge_total;
  verdict_t pending_verdicts[$];
  int       mismatches;
  int       results_seen;
  int       items_sent;
  int       queries_sent;
  int       full_drops;
  bit       quiet;  // when set, neither side idles

  // Depth-first walk of parent edges from start, with a visited map so
  // that cyclic graphs terminate. The start node itself is not marked.
  function automatic logic reaches_ancestor(term_t start, term_t target);
    bit    seen[NODE_COUNT];
    term_t stack[NODE_COUNT];
    int    depth;
    term_t node;
    logic  found;
    found = 1'b0;
    depth = 0;
    node  = start;
    forever begin
      for (int i = 0; i < edge_total; i++) begin
        if (edge_child[i] == node && !seen[edge_parent[i]]) begin
          seen[edge_parent[i]] = 1'b1;
          stack[depth] = edge_parent[i];
          depth++;
        end
      end
      if (depth == 0) break;
      depth--;
      node = stack[depth];
      if (node == target) begin
        found = 1'b1;
        break;
      end
    end
    return found;
  endfunction

  // Applies one accepted item to the graph model and returns its result.
  function automatic verdict_t apply_item(cmd_t cmd, term_t a, term_t b);
    verdict_t v;
    v = '{1'b0, 1'b0, 1'b0};
    case (cmd)
      CMD_CLEAR: edge_total = 0;
      CMD_ADD: begin
        if (edge_total >= MAX_EDGES) begin
          v.status = 1'b1;
        end else begin
          edge_child[edge_total]  = a;
          edge_parent[edge_total] = b;
          edge_total++;
        end
      end
      CMD_QUERY: begin
        v.is_same     = (a == b);
        v.is_ancestor = reaches_ancestor(a, b);
      end
      default: ;
    endcase
    return v;
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    $display("ERROR %0t: %s", $time, what);
  endtask

  // Random idle cycles on the input side, about 17 times in a hundred.
  task automatic maybe_idle();
    if (!quiet && $urandom_range(0, 99) < 17) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // Drives one item and holds it until the transfer happens. Valid stays
  // high afterwards; only an idle gap before the next item drops it.
  task automatic send_item(cmd_t cmd, term_t a, term_t b, bit has_exp,
                           verdict_t typed);
    verdict_t v;
    maybe_idle();
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= cmd;
    in_ch.term       <= a;
    in_ch.other_term <= b;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    v = apply_item(cmd, a, b);
    if (has_exp) v = typed;
    pending_verdicts.push_back(v);
    items_sent++;
    if (cmd == CMD_QUERY) queries_sent++;
    if (v.status) full_drops++;
  endtask

  task automatic send_plain(cmd_t cmd, term_t a, term_t b);
    send_item(cmd, a, b, 1'b0, '{1'b0, 1'b0, 1'b0});
  endtask

  // Result side: every transfer is checked against the oldest expectation.
  always @(posedge clk) begin
    verdict_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (pending_verdicts.size() == 0) begin
        report_mismatch("result transfer with nothing expected");
      end else begin
        e = pending_verdicts[0];
        pending_verdicts.delete(0);
        if (out_ch.is_ancestor !== e.is_ancestor)
          report_mismatch($sformatf("is_ancestor got %b exp %b",
                                    out_ch.is_ancestor, e.is_ancestor));
        if (out_ch.is_same !== e.is_same)
          report_mismatch($sformatf("is_same got %b exp %b",
                                    out_ch.is_same, e.is_same));
        if (out_ch.status !== e.status)
          report_mismatch($sformatf("status got %b exp %b",
                                    out_ch.status, e.status));
      end
    end
    out_ch.ready <= quiet || ($urandom_range(0, 99) >= 17);
  end

  // Directed rows: the empty table, equal terms, the unused code, a short
  // chain, a cycle back to the start, the extreme terms and a clear.
  row_t rows[] = '{
    '{CMD_QUERY, 10'd5,    10'd9,    1'b1, 1'b0, 1'b0, 1'b0},
    '{CMD_QUERY, 10'd1023, 10'd1023, 1'b1, 1'b0, 1'b1, 1'b0},
    '{CMD_NONE,  10'd1023, 10'd0,    1'b1, 1'b0, 1'b0, 1'b0},
    '{CMD_ADD,   10'd5,    10'd7,    1'b1, 1'b0, 1'b0, 1'b0},
    '{CMD_ADD,   10'd7,    10'd9,    1'b1, 1'b0, 1'b0, 1'b0},
    '{CMD_QUERY, 10'd5,    10'd9,    1'b0, 1'b0, 1'b0, 1'b0},
    '{CMD_QUERY, 10'd9,    10'd5,    1'b0, 1'b0, 1'b0, 1'b0},
    '{CMD_QUERY, 10'd5,    10'd5,    1'b0, 1'b0, 1'b0, 1'b0},
    '{CMD_ADD,   10'd9,    10'd5,    1'b1, 1'b0, 1'b0, 1'b0},
    '{CMD_QUERY, 10'd5,    10'd5,    1'b0, 1'b0, 1'b0, 1'b0},
    '{CMD_QUERY, 10'd7,    10'd5,    1'b0, 1'b0, 1'b0, 1'b0},
    '{CMD_ADD,   10'd1023, 10'd0,    1'b1, 1'b0, 1'b0, 1'b0},
    '{CMD_ADD,   10'd0,    10'd1023, 1'b1, 1'b0, 1'b0, 1'b0},
    '{CMD_QUERY, 10'd1023, 10'd1023, 1'b0, 1'b0, 1'b0, 1'b0},
    '{CMD_QUERY, 10'd0,    10'd1023, 1'b0, 1'b0, 1'b0, 1'b0},
    '{CMD_NONE,  10'd0,    10'd1023, 1'b1, 1'b0, 1'b0, 1'b0},
    '{CMD_QUERY, 10'd1023, 10'd1023, 1'b0, 1'b0, 1'b0, 1'b0},
    '{CMD_CLEAR, 10'd0,    10'd0,    1'b1, 1'b0, 1'b0, 1'b0},
    '{CMD_QUERY, 10'd5,    10'd9,    1'b1, 1'b0, 1'b0, 1'b0}
  };

  // Stimulus. Each random phase builds a small graph over a pool of terms
  // and queries it; one phase fills the table past its limit, with few
  // distinct terms so that each query expands only a handful of nodes.
  initial begin
    term_t pool[16];
    int    pool_n;
    int    phase;
    int    n_edges;
    int    n_queries;
    int    sel;
    term_t a;
    term_t b;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.cmd        = CMD_CLEAR;
    in_ch.term       = '0;
    in_ch.other_term = '0;
    out_ch.ready     = 1'b0;
    edge_total       = 0;
    mismatches       = 0;
    results_seen     = 0;
    items_sent       = 0;
    queries_sent     = 0;
    full_drops       = 0;
    quiet            = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i])
      send_item(rows[i].cmd, rows[i].term, rows[i].other, rows[i].has_exp,
                '{rows[i].anc, rows[i].same, rows[i].full});

    phase = 0;
    while (items_sent < 650 || phase < 4) begin
      // The second phase runs with no idling on either side.
      quiet = (phase == 1);
      if (phase != 0 && $urandom_range(0, 3) != 0) send_plain(CMD_CLEAR, '0, '0);
      pool_n = (phase == 3) ? 6 : $urandom_range(3, 16);
      for (int i = 0; i < pool_n; i++) pool[i] = term_t'($urandom_range(0, 1023));
      n_edges   = (phase == 3) ? MAX_EDGES + 4 : $urandom_range(0, 20);
      n_queries = (phase == 3) ? 5 : $urandom_range(4, 14);
      for (int i = 0; i < n_edges; i++) begin
        a = pool[$urandom_range(0, pool_n - 1)];
        b = pool[$urandom_range(0, pool_n - 1)];
        if ($urandom_range(0, 29) == 0) send_plain(CMD_NONE, a, b);
        send_plain(CMD_ADD, a, b);
      end
      for (int i = 0; i < n_queries; i++) begin
        sel = $urandom_range(0, 9);
        a   = pool[$urandom_range(0, pool_n - 1)];
        b   = pool[$urandom_range(0, pool_n - 1)];
        if (sel == 0) b = a;
        if (sel == 1) a = term_t'($urandom_range(0, 1023));
        if (sel == 2) b = term_t'($urandom_range(0, 1023));
        send_plain(CMD_QUERY, a, b);
      end
      phase++;
    end
    in_ch.valid <= 1'b0;
    quiet = 1'b0;

    for (int w = 0; w < 2000000 && pending_verdicts.size() != 0; w++)
      @(posedge clk);
    repeat (50) @(posedge clk);
    if (pending_verdicts.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_verdicts.size()));

    $display("Run covered %0d transfers in, %0d results, %0d queries, %0d phases,",
             items_sent, results_seen, queries_sent, phase);
    $display("and %0d edges dropped at a full table.", full_drops);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #50ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

/* files.f */
rtl/core/das_pkg.sv
rtl/core/das_if.sv
rtl/core/das_ram.sv
rtl/core/das_datapath.sv
rtl/core/das_ctrl.sv
rtl/core/dag_ancestor_search_top.sv
test/tb_top.sv
